>>> rtl/wide_line_to_triangles_top_assert.svh
// ----------------------------------------------------------------------------
// Wide line to triangles assertion macros
// Shared macros for the concurrent checks of the wide line expander.
// ----------------------------------------------------------------------------
`ifndef WIDE_LINE_TO_TRIANGLES_TOP_ASSERT_SVH
`define WIDE_LINE_TO_TRIANGLES_TOP_ASSERT_SVH

// Check that is skipped while reset is asserted.
`define WLTT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check that also holds during reset.
`define WLTT_ASSERT_ANY(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/wltt_pkg.sv
// ----------------------------------------------------------------------------
// Wide line to triangles package
// Shared constants and the classified segment record.
// ----------------------------------------------------------------------------
`default_nettype none

package wltt_pkg;

  localparam int FracBitsDefault = 16;
  localparam int CoordW          = 16;
  localparam int VertW           = 17;
  localparam int LineWidthW      = 10;
  localparam int PaintW          = 32;
  localparam int SqW             = 32;
  localparam int QueueDepth      = 2;

  typedef struct packed {
    logic signed [CoordW-1:0] start_x;
    logic signed [CoordW-1:0] start_y;
    logic signed [CoordW-1:0] end_x;
    logic signed [CoordW-1:0] end_y;
    logic [LineWidthW-1:0]    width;
    logic [PaintW-1:0]        paint;
    logic [SqW-1:0]           dx2;
    logic [SqW-1:0]           dy2;
    logic                     nx_neg;
    logic                     ny_neg;
    logic                     zero_len;
  } seg_t;

endpackage

`default_nettype wire

>>> rtl/wltt_if.sv
// ----------------------------------------------------------------------------
// Wide line to triangles channel interfaces
// Segment request channel and triangle result channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface wltt_line_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [wltt_pkg::CoordW-1:0]    start_x;
  logic signed [wltt_pkg::CoordW-1:0]    start_y;
  logic signed [wltt_pkg::CoordW-1:0]    end_x;
  logic signed [wltt_pkg::CoordW-1:0]    end_y;
  logic [wltt_pkg::LineWidthW-1:0]       width;
  logic [wltt_pkg::PaintW-1:0]           paint;

  modport source (output valid, start_x, start_y, end_x, end_y, width, paint,
                  input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, width, paint,
                output ready);
endinterface

interface wltt_tri_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [wltt_pkg::VertW-1:0]     vert0_x;
  logic signed [wltt_pkg::VertW-1:0]     vert0_y;
  logic signed [wltt_pkg::VertW-1:0]     vert1_x;
  logic signed [wltt_pkg::VertW-1:0]     vert1_y;
  logic signed [wltt_pkg::VertW-1:0]     vert2_x;
  logic signed [wltt_pkg::VertW-1:0]     vert2_y;
  logic [wltt_pkg::PaintW-1:0]           tri_paint;
  logic                                  last_tri;

  modport source (output valid, vert0_x, vert0_y, vert1_x, vert1_y, vert2_x,
                  vert2_y, tri_paint, last_tri, input ready);
  modport sink (input valid, vert0_x, vert0_y, vert1_x, vert1_y, vert2_x,
                vert2_y, tri_paint, last_tri, output ready);
endinterface

`default_nettype wire

>>> rtl/wltt_front.sv
// ----------------------------------------------------------------------------
// Wide line to triangles front end
// Accepts segment requests and forms the deltas, their squares and signs.
// ----------------------------------------------------------------------------
`default_nettype none

module wltt_front (
  wltt_line_if.sink       line_i,
  input  wire logic       q_ready_i,
  output wltt_pkg::seg_t  q_item_o,
  output logic            q_valid_o
);

  logic signed [wltt_pkg::CoordW:0] dx, dy;
  logic [wltt_pkg::CoordW-1:0]      adx, ady;

  always_comb begin
    dx  = {line_i.end_x[wltt_pkg::CoordW-1], line_i.end_x}
        - {line_i.start_x[wltt_pkg::CoordW-1], line_i.start_x};
    dy  = {line_i.end_y[wltt_pkg::CoordW-1], line_i.end_y}
        - {line_i.start_y[wltt_pkg::CoordW-1], line_i.start_y};
    adx = dx[wltt_pkg::CoordW] ? wltt_pkg::CoordW'(-dx) : dx[wltt_pkg::CoordW-1:0];
    ady = dy[wltt_pkg::CoordW] ? wltt_pkg::CoordW'(-dy) : dy[wltt_pkg::CoordW-1:0];

    q_item_o.start_x  = line_i.start_x;
    q_item_o.start_y  = line_i.start_y;
    q_item_o.end_x    = line_i.end_x;
    q_item_o.end_y    = line_i.end_y;
    q_item_o.width    = line_i.width;
    q_item_o.paint    = line_i.paint;
    q_item_o.dx2      = adx * adx;
    q_item_o.dy2      = ady * ady;
    q_item_o.nx_neg   = !dy[wltt_pkg::CoordW] && (dy != '0);
    q_item_o.ny_neg   = dx[wltt_pkg::CoordW];
    q_item_o.zero_len = (dx == '0) && (dy == '0);
  end

  assign q_valid_o    = line_i.valid;
  assign line_i.ready = q_ready_i;

endmodule

`default_nettype wire

>>> rtl/wltt_queue.sv
// ----------------------------------------------------------------------------
// Wide line to triangles queue
// Two-entry queue of classified segments between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module wltt_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            wr_valid_i,
  input  wltt_pkg::seg_t       wr_item_i,
  output logic                 wr_ready_o,
  output logic                 rd_valid_o,
  input  wire logic            rd_ready_i,
  output wltt_pkg::seg_t       rd_item_o
);

  localparam int PtrW = $clog2(wltt_pkg::QueueDepth);

  wltt_pkg::seg_t   mem_q [wltt_pkg::QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]    cnt_q, cnt_d;
  logic             push, pop;

  assign wr_ready_o = (cnt_q != (PtrW+1)'(wltt_pkg::QueueDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_item_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/wltt_back.sv
// ----------------------------------------------------------------------------
// Wide line to triangles back end
// Pipelined unit-normal root search, offset scaling, corners and emission.
// ----------------------------------------------------------------------------
`default_nettype none

`include "wide_line_to_triangles_top_assert.svh"

module wltt_back #(
  parameter int FRAC_BITS = wltt_pkg::FracBitsDefault
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        q_valid_i,
  input  wltt_pkg::seg_t   q_item_i,
  output logic             q_ready_o,
  wltt_tri_if.source       tri_o
);

  localparam int F  = FRAC_BITS;
  localparam int NS = F + 1;
  localparam int RW = 2 * F + 40;
  localparam int UW = F + 1;
  localparam int OW = F + 11;
  localparam int CW = F + 19;
  localparam int VW = wltt_pkg::VertW;
  localparam int LW_PAD = wltt_pkg::LineWidthW;

  typedef struct packed {
    wltt_pkg::seg_t  seg;
    logic [RW-1:0]   rx;
    logic [RW-1:0]   ry;
    logic [RW-1:0]   px;
    logic [RW-1:0]   py;
    logic [RW-1:0]   sq;
    logic [UW-1:0]   ux;
    logic [UW-1:0]   uy;
  } root_t;

  typedef struct packed {
    wltt_pkg::seg_t        seg;
    logic signed [OW-1:0]  ox;
    logic signed [OW-1:0]  oy;
  } offs_t;

  function automatic logic signed [VW-1:0] corner(
    input logic signed [wltt_pkg::CoordW-1:0] p,
    input logic signed [OW-1:0]               off,
    input logic                               sub
  );
    logic signed [CW-1:0] s;
    logic signed [CW-1:0] q;
    s = (CW'(p) <<< F);
    s = sub ? (s - CW'(off)) : (s + CW'(off));
    if (s[CW-1]) begin
      s = s + CW'((1 << F) - 1);
    end
    q = s >>> F;
    return q[VW-1:0];
  endfunction

  root_t  st_q   [NS+1];
  logic   st_vld_q [NS+1];
  root_t  st_d   [NS+1];
  offs_t  off_q, off_d;
  logic   off_vld_q;

  logic signed [VW-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q, dx_q, dy_q;
  logic [wltt_pkg::PaintW-1:0] paint_q;
  logic   emit_vld_q;
  logic   phase_q;
  logic   adv;
  logic   fire;

  assign fire      = tri_o.valid && tri_o.ready;
  assign adv       = !emit_vld_q || (tri_o.ready && phase_q);
  assign q_ready_o = adv;

  always_comb begin
    st_d[0]     = '0;
    st_d[0].seg = q_item_i;
    st_d[0].rx  = RW'(q_item_i.dy2) << (2 * F);
    st_d[0].ry  = RW'(q_item_i.dx2) << (2 * F);
    st_d[0].sq  = RW'(q_item_i.dx2) + RW'(q_item_i.dy2);
  end

  for (genvar k = 0; k < NS; k++) begin : g_root
    localparam int B = F - k;
    logic [RW-1:0] tx, ty;

    always_comb begin
      st_d[k+1] = st_q[k];
      tx = (st_q[k].px << (B + 1)) + (st_q[k].sq << (2 * B));
      ty = (st_q[k].py << (B + 1)) + (st_q[k].sq << (2 * B));
      if (st_q[k].rx >= tx) begin
        st_d[k+1].rx    = st_q[k].rx - tx;
        st_d[k+1].px    = st_q[k].px + (st_q[k].sq << B);
        st_d[k+1].ux[B] = 1'b1;
      end
      if (st_q[k].ry >= ty) begin
        st_d[k+1].ry    = st_q[k].ry - ty;
        st_d[k+1].py    = st_q[k].py + (st_q[k].sq << B);
        st_d[k+1].uy[B] = 1'b1;
      end
    end
  end

  always_comb begin
    logic [UW-1:0]            ux, uy;
    logic [UW+LW_PAD-1:0]     mx, my;
    ux = st_q[NS].seg.zero_len ? '0 : st_q[NS].ux;
    uy = st_q[NS].seg.zero_len ? '0 : st_q[NS].uy;
    mx = (UW+LW_PAD)'(st_q[NS].seg.width) * (UW+LW_PAD)'(ux);
    my = (UW+LW_PAD)'(st_q[NS].seg.width) * (UW+LW_PAD)'(uy);
    mx = mx >> 1;
    my = my >> 1;
    off_d.seg = st_q[NS].seg;
    off_d.ox  = st_q[NS].seg.nx_neg ? -OW'(mx) : OW'(mx);
    off_d.oy  = st_q[NS].seg.ny_neg ? -OW'(my) : OW'(my);
  end

  for (genvar k = 0; k <= NS; k++) begin : g_stage
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_vld_q[k] <= 1'b0;
      end else if (adv) begin
        st_vld_q[k] <= (k == 0) ? q_valid_i : st_vld_q[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_vld_q  <= 1'b0;
      emit_vld_q <= 1'b0;
      phase_q    <= 1'b0;
    end else begin
      if (adv) begin
        off_vld_q  <= st_vld_q[NS];
        emit_vld_q <= off_vld_q;
        phase_q    <= 1'b0;
      end else if (fire && !phase_q) begin
        phase_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      off_q   <= off_d;
      ax_q    <= corner(off_q.seg.start_x, off_q.ox, 1'b0);
      ay_q    <= corner(off_q.seg.start_y, off_q.oy, 1'b0);
      cx_q    <= corner(off_q.seg.start_x, off_q.ox, 1'b1);
      cy_q    <= corner(off_q.seg.start_y, off_q.oy, 1'b1);
      bx_q    <= corner(off_q.seg.end_x, off_q.ox, 1'b0);
      by_q    <= corner(off_q.seg.end_y, off_q.oy, 1'b0);
      dx_q    <= corner(off_q.seg.end_x, off_q.ox, 1'b1);
      dy_q    <= corner(off_q.seg.end_y, off_q.oy, 1'b1);
      paint_q <= off_q.seg.paint;
    end
  end

  assign tri_o.valid     = emit_vld_q;
  assign tri_o.vert0_x   = ax_q;
  assign tri_o.vert0_y   = ay_q;
  assign tri_o.vert1_x   = phase_q ? dx_q : cx_q;
  assign tri_o.vert1_y   = phase_q ? dy_q : cy_q;
  assign tri_o.vert2_x   = phase_q ? bx_q : dx_q;
  assign tri_o.vert2_y   = phase_q ? by_q : dy_q;
  assign tri_o.tri_paint = paint_q;
  assign tri_o.last_tri  = phase_q;

  `WLTT_ASSERT_ANY(a_phase_needs_item, phase_q |-> emit_vld_q,
                   "Second triangle phase without a held segment.")
  `WLTT_ASSERT_RST(a_first_then_second, fire && !phase_q |=> emit_vld_q && phase_q,
                   "First triangle was not followed by the second.")
  `WLTT_ASSERT_RST(a_stall_on_pending, emit_vld_q && !(phase_q && tri_o.ready) |-> !adv,
                   "Pipeline advanced while a triangle was still pending.")

endmodule

`default_nettype wire

>>> rtl/wide_line_to_triangles_top.sv
// ----------------------------------------------------------------------------
// Wide line to triangles top level
// Expands a wide line segment request into two triangle results.
// ----------------------------------------------------------------------------
// Usage: the segment channel line_i takes one request (endpoints, width and
// paint) at every edge where valid and ready are both high. For each request
// the triangle channel tri_o delivers two results: (a,c,d) with last_tri low,
// then (a,d,b) with last_tri high, both carrying the request's paint.
// The front end classifies a request in the cycle it arrives and writes it
// into a two-entry queue. The back end runs a pipelined square-root search
// with FRAC_BITS + 1 stages, then scales the offset and forms corners.
// The back end takes a new request only once both triangles of the held
// one are accepted, since the two triangles share the same corner registers.
// While tri_o is stalled the back end holds, the queue fills, and line_i
// drops ready once both queue entries are taken.
// Reset empties the queue and the pipeline; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module wide_line_to_triangles_top #(
  parameter int FRAC_BITS = wltt_pkg::FracBitsDefault
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  wltt_line_if.sink     line_i,
  wltt_tri_if.source    tri_o
);

  wltt_pkg::seg_t  fq_item, qb_item;
  logic            fq_valid, fq_ready, qb_valid, qb_ready;

  wltt_front u_front (
    .line_i    (line_i),
    .q_ready_i (fq_ready),
    .q_item_o  (fq_item),
    .q_valid_o (fq_valid)
  );

  wltt_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fq_valid),
    .wr_item_i  (fq_item),
    .wr_ready_o (fq_ready),
    .rd_valid_o (qb_valid),
    .rd_ready_i (qb_ready),
    .rd_item_o  (qb_item)
  );

  wltt_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (qb_valid),
    .q_item_i  (qb_item),
    .q_ready_o (qb_ready),
    .tri_o     (tri_o)
  );

endmodule

`default_nettype wire

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// Wide line to triangles testbench
// Drives random and edge-case segment requests into the expander and checks
// each triangle result against a fixed-point prediction of the quad corners.
// ----------------------------------------------------------------------------
`default_nettype none

class tri_scoreboard;
  typedef struct packed {
    logic [16:0] v0x, v0y, v1x, v1y, v2x, v2y;
    logic [31:0] paint;
    logic        last;
  } tri_t;

  tri_t pending_tris[$];
  int   errors;
  int   checked;

  function longint unsigned unit_mag(longint unsigned nabs, longint unsigned sq);
    longint unsigned m, t;
    logic [127:0] lhs, rhs;
    m = 0;
    if (sq == 0) return 0;
    rhs = 128'(nabs * nabs) << 32;
    for (int b = 16; b >= 0; b--) begin
      t = m | (64'd1 << b);
      lhs = 128'(t * t) * 128'(sq);
      if (lhs <= rhs) m = t;
    end
    return m;
  endfunction

  function longint offset_of(longint n, longint unsigned sq, longint unsigned w);
    longint unsigned nabs;
    longint mag;
    nabs = (n < 0) ? -n : n;
    mag = (w * unit_mag(nabs, sq)) / 2;
    return (n < 0) ? -mag : mag;
  endfunction

  function logic [16:0] corner(longint p, longint off);
    longint s;
    s = p * 65536 + off;
    return 17'(s / 65536);
  endfunction

  function void note_line(logic signed [15:0] sx, sy, ex, ey, logic [9:0] w,
                          logic [31:0] paint);
    longint dx, dy, ox, oy;
    longint unsigned sq;
    logic [16:0] ax, ay, bx, by, cx, cy, qx, qy;
    tri_t t;
    dx = longint'(ex) - longint'(sx);
    dy = longint'(ey) - longint'(sy);
    sq = dx * dx + dy * dy;
    ox = offset_of(-dy, sq, w);
    oy = offset_of(dx, sq, w);
    ax = corner(sx, ox); ay = corner(sy, oy);
    cx = corner(sx, -ox); cy = corner(sy, -oy);
    bx = corner(ex, ox); by = corner(ey, oy);
    qx = corner(ex, -ox); qy = corner(ey, -oy);
    t = '{ax, ay, cx, cy, qx, qy, paint, 1'b0};
    pending_tris.push_back(t);
    t = '{ax, ay, qx, qy, bx, by, paint, 1'b1};
    pending_tris.push_back(t);
  endfunction

  function void check_tri(tri_t got);
    tri_t e;
    if (pending_tris.size() == 0) begin
      $display("%0t: unexpected triangle %p", $time, got);
      errors++;
      return;
    end
    e = pending_tris.pop_front();
    checked++;
    if (got != e) begin
      $display("%0t: mismatch expected %p actual %p", $time, e, got);
      errors++;
    end
  endfunction
endclass

module testbench;
  logic clk_i = 0;
  logic rst_ni = 0;
  wltt_line_if line_if ();
  wltt_tri_if  tri_if ();
  tri_scoreboard sb = new();
  int idle_cycles = 0;
  int lines_sent = 0;

  wide_line_to_triangles_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .line_i(line_if.sink), .tri_o(tri_if.source)
  );

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  initial begin
    line_if.valid = 0; line_if.start_x = 0; line_if.start_y = 0;
    line_if.end_x = 0; line_if.end_y = 0; line_if.width = 0; line_if.paint = 0;
    tri_if.ready = 0;
  end

  task automatic send_line(logic [15:0] sx, sy, ex, ey, logic [9:0] w, logic [31:0] p);
    int gap;
    gap = $urandom_range(0, 3);
    if (gap > 0) begin
      line_if.valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    line_if.valid <= 1; line_if.start_x <= sx; line_if.start_y <= sy;
    line_if.end_x <= ex; line_if.end_y <= ey; line_if.width <= w; line_if.paint <= p;
    do @(posedge clk_i); while (!line_if.ready);
    sb.note_line(sx, sy, ex, ey, w, p);
    lines_sent++;
  endtask

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 64) - 32);
      2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom_range(0, 2000) - 1000);
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (tri_if.valid && tri_if.ready)
      sb.check_tri('{tri_if.vert0_x, tri_if.vert0_y, tri_if.vert1_x, tri_if.vert1_y,
                     tri_if.vert2_x, tri_if.vert2_y, tri_if.tri_paint, tri_if.last_tri});
  end

  initial begin
    int wait_left;
    forever begin
      @(posedge clk_i);
      if (wait_left > 0) begin
        wait_left--;
        tri_if.ready <= 0;
      end else begin
        if (tri_if.valid && tri_if.ready) begin
          wait_left = $urandom_range(0, 3);
          if (wait_left > 0) tri_if.ready <= 0;
        end else tri_if.ready <= rst_ni;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((line_if.valid && line_if.ready) || (tri_if.valid && tri_if.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [15:0] sx, sy;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    send_line(0, 0, 0, 0, 10, 32'h0);
    send_line(5, 5, 5, 5, 1023, 32'hffffffff);
    send_line(16'h8000, 16'h8000, 16'h7fff, 16'h7fff, 1023, 32'hdeadbeef);
    send_line(16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 1023, 32'h12345678);
    send_line(16'h8000, 16'h7fff, 16'h8000, 16'h8000, 1023, 32'haaaaaaaa);
    send_line(16'h7fff, 0, 16'h8000, 0, 1023, 32'h55555555);
    send_line(0, 0, 100, 0, 0, 32'h1);
    send_line(0, 0, 0, 100, 1, 32'h2);
    send_line(0, 0, -100, 0, 7, 32'h3);
    send_line(0, 0, 0, -100, 513, 32'h4);
    send_line(0, 0, 3, 4, 10, 32'h5);
    send_line(0, 0, -3, -4, 11, 32'h6);
    send_line(0, 0, 1, 1, 1023, 32'h7);
    send_line(-10, 20, 30, -40, 512, 32'h8);
    repeat (850) begin
      sx = rand_coord(); sy = rand_coord();
      if ($urandom_range(0, 15) == 0)
        send_line(sx, sy, sx, sy, 10'($urandom), $urandom);
      else if ($urandom_range(0, 1))
        send_line(sx, sy, sx + 16'($urandom_range(0, 60) - 30),
                  sy + 16'($urandom_range(0, 60) - 30), 10'($urandom), $urandom);
      else
        send_line(sx, sy, rand_coord(), rand_coord(), 10'($urandom), $urandom);
    end
    line_if.valid <= 0;
    while (sb.pending_tris.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    $display("Sent %0d segment requests, checked %0d triangles.", lines_sent, sb.checked);
    if (sb.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

`default_nettype wire
